@@ hdl/rgb_led_chain_pwm_driver_defines.svh @@
// Assertion macros shared by the LED chain driver RTL.
`ifndef RGB_LED_CHAIN_PWM_DRIVER_DEFINES_SVH
`define RGB_LED_CHAIN_PWM_DRIVER_DEFINES_SVH

// Same-cycle implication, checked on i_clk with i_rst_n as the disable.
`define RLCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk with i_rst_n as the disable.
`define RLCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rlcd_pkg.sv @@
// Types, codes and constants of the LED chain driver.
`timescale 1ns / 1ps

package rlcd_pkg;

    // Colour word and configuration port sizes.
    localparam int COLOUR_W     = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int DUTY_W       = 8;
    localparam int IDLE_W       = 10;
    localparam int LEDS_W       = 5;
    localparam int LED_INDEX_W  = 5;

    // Default sizes of the chain.
    localparam int MAX_LEDS_DEF     = 24;
    localparam int BITS_PER_LED_DEF = 24;

    // Register values after reset.
    localparam logic [DUTY_W-1:0] LOW_DUTY_RST    = 8'd13;
    localparam logic [DUTY_W-1:0] HIGH_DUTY_RST   = 8'd26;
    localparam logic [DUTY_W-1:0] PERIOD_LAST_RST = 8'd39;
    localparam logic [IDLE_W-1:0] IDLE_SLOTS_RST  = 10'd120;
    localparam logic [LEDS_W-1:0] LEDS_IN_USE_RST = 5'd24;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2,
        OP_TICK  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_DUTY    = 3'd0,
        CFG_HIGH_DUTY   = 3'd1,
        CFG_PERIOD_LAST = 3'd2,
        CFG_IDLE_SLOTS  = 3'd3,
        CFG_LEDS_IN_USE = 3'd4
    } t_cfg_idx;

    typedef logic [COLOUR_W-1:0] t_colour;

    typedef struct packed {
        t_opcode                opcode;
        logic [LED_INDEX_W-1:0] led_index;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
    } t_in_word;

    typedef struct packed {
        logic line_out;
        logic busy_res;
        logic frame_done;
    } t_out_word;

endpackage

@@ hdl/rlcd_colour_mem.sv @@
// Colour store: synchronous RAM with write forwarding and a clearing pass after reset.
`timescale 1ns / 1ps

module rlcd_colour_mem #(
    parameter int DEPTH  = rlcd_pkg::MAX_LEDS_DEF,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  rlcd_pkg::t_colour i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output rlcd_pkg::t_colour o_rd_data,
    output logic              o_clearing
);
    import rlcd_pkg::*;

    t_colour           r_mem [DEPTH];
    t_colour           r_rd_data;
    t_colour           r_fwd_data;
    logic              r_fwd_hit;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    t_colour           w_data;

    // The clearing pass owns the write port until every entry holds zero.
    always_comb begin
        if (r_clearing) begin
            w_en   = 1'b1;
            w_addr = r_clr_addr;
            w_data = '0;
        end else begin
            w_en   = i_wr_en;
            w_addr = i_wr_addr;
            w_data = i_wr_data;
        end
    end

    // Clearing pass: one entry a cycle from the bottom of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Storage array, written and read on the same edge.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // A write to the entry being read returns the new word on the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= w_en && (w_addr == i_rd_addr);
        end
        r_fwd_data <= w_data;
    end

    assign o_rd_data  = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign o_clearing = r_clearing;

endmodule

@@ hdl/rlcd_slot_div.sv @@
// Maps the next bit period to an LED address and, in the following cycle, a bit position.
`timescale 1ns / 1ps

module rlcd_slot_div #(
    parameter int MAX_LEDS     = rlcd_pkg::MAX_LEDS_DEF,
    parameter int BITS_PER_LED = rlcd_pkg::BITS_PER_LED_DEF,
    parameter int SLOT_W       = 11,
    parameter int ADDR_W       = 5,
    parameter int POS_W        = 5
) (
    input  logic                        i_clk,
    input  logic [SLOT_W-1:0]           i_slot_next,
    input  logic [rlcd_pkg::IDLE_W-1:0] i_idle_next,
    output logic [ADDR_W-1:0]           o_rd_addr,
    output logic [POS_W-1:0]            o_pos
);
    import rlcd_pkg::*;

    // Reciprocal of the bit count, exact for every offset below 2**SLOT_W.
    localparam int SHIFT  = SLOT_W + POS_W;
    localparam int RECIP  = ((1 << SHIFT) + BITS_PER_LED - 1) / BITS_PER_LED;
    localparam int PROD_W = 2 * SLOT_W + POS_W + 1;

    logic [SLOT_W-1:0] w_d;
    logic [PROD_W-1:0] w_prod;
    logic [SLOT_W-1:0] w_q;
    logic [SLOT_W-1:0] r_d;
    logic [SLOT_W-1:0] r_q;
    logic [SLOT_W-1:0] w_rem;

    // Offset into the LED data and its quotient by the bits per LED.
    always_comb begin
        w_d    = i_slot_next - SLOT_W'(i_idle_next);
        w_prod = PROD_W'(w_d) * PROD_W'(RECIP);
        w_q    = w_prod[SHIFT +: SLOT_W];
    end

    // An offset outside the chain reads entry zero; its data is not used.
    assign o_rd_addr = (w_q < SLOT_W'(MAX_LEDS)) ? ADDR_W'(w_q) : '0;

    always_ff @(posedge i_clk) begin
        r_d <= w_d;
        r_q <= w_q;
    end

    // Remainder gives the bit position within the LED word.
    assign w_rem = r_d - r_q * SLOT_W'(BITS_PER_LED);
    assign o_pos = POS_W'(w_rem);

endmodule

@@ hdl/rgb_led_chain_pwm_driver.sv @@
// Top level of the single-wire RGB LED chain driver.
// Stage one executes an accepted word and its result is registered in the output register.
// Throughput: one word per cycle unless i_out_stall or the clearing pass holds the flow; the
// colour store read for the next bit period is issued from the next frame state, so one read
// port keeps up with a tick on every cycle. Reset: registers take reset values at once, then
// a clearing pass zeroes the colour store while o_in_stall stays high; config writes are taken.
`timescale 1ns / 1ps

module rgb_led_chain_pwm_driver #(
    parameter int MAX_LEDS     = rlcd_pkg::MAX_LEDS_DEF,
    parameter int BITS_PER_LED = rlcd_pkg::BITS_PER_LED_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rlcd_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rlcd_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_we,
    input  logic [rlcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rlcd_pkg::*;

    `include "rgb_led_chain_pwm_driver_defines.svh"

    localparam int IDLE_MAX  = (1 << IDLE_W) - 1;
    localparam int SLOT_W    = $clog2(IDLE_MAX + 1 + MAX_LEDS * BITS_PER_LED);
    localparam int ADDR_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int POS_W     = $clog2(BITS_PER_LED);
    localparam int LEDS_RST  = (int'(LEDS_IN_USE_RST) > MAX_LEDS) ? MAX_LEDS
                                                                  : int'(LEDS_IN_USE_RST);
    localparam int TOTAL_RST = int'(IDLE_SLOTS_RST) + LEDS_RST * BITS_PER_LED;

    // Configuration registers and their next values.
    logic [DUTY_W-1:0] r_low_duty,    n_low_duty;
    logic [DUTY_W-1:0] r_high_duty,   n_high_duty;
    logic [DUTY_W-1:0] r_period_last, n_period_last;
    logic [IDLE_W-1:0] r_idle_slots,  n_idle_slots;
    logic [LEDS_W-1:0] r_leds_in_use, n_leds_in_use;
    logic [SLOT_W-1:0] r_total,       n_total;
    logic [SLOT_W-1:0] w_leds_sent;

    // Frame state.
    logic              r_sending, n_sending;
    logic [SLOT_W-1:0] r_slot,    n_slot;
    logic [DUTY_W-1:0] r_tick,    n_tick;
    logic [SLOT_W-1:0] w_slot_inc;

    // Pipeline registers.
    logic              r_s1_valid;
    t_in_word          r_s1_word;
    logic              r_out_valid;
    t_out_word         r_out_word;
    t_out_word         w_result;
    logic              w_out_ready;
    logic              w_s1_fire;
    logic              w_in_accept;

    // Colour store interface.
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    t_colour           w_wr_data;
    logic [ADDR_W-1:0] w_rd_addr;
    t_colour           w_colour;
    logic              w_clearing;
    logic [POS_W-1:0]  w_pos;
    t_colour           w_colour_sh;
    logic              w_bit;
    logic [DUTY_W-1:0] w_duty;

    // Decode a configuration write into the next register values.
    always_comb begin
        n_low_duty    = r_low_duty;
        n_high_duty   = r_high_duty;
        n_period_last = r_period_last;
        n_idle_slots  = r_idle_slots;
        n_leds_in_use = r_leds_in_use;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOW_DUTY:    n_low_duty    = i_cfg_data[DUTY_W-1:0];
                CFG_HIGH_DUTY:   n_high_duty   = i_cfg_data[DUTY_W-1:0];
                CFG_PERIOD_LAST: n_period_last = i_cfg_data[DUTY_W-1:0];
                CFG_IDLE_SLOTS:  n_idle_slots  = i_cfg_data[IDLE_W-1:0];
                CFG_LEDS_IN_USE: n_leds_in_use = i_cfg_data[LEDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Frame length in bit periods, with the LED count limited to the store depth.
    always_comb begin
        if (SLOT_W'(n_leds_in_use) > SLOT_W'(MAX_LEDS)) begin
            w_leds_sent = SLOT_W'(MAX_LEDS);
        end else begin
            w_leds_sent = SLOT_W'(n_leds_in_use);
        end
        n_total = SLOT_W'(n_idle_slots) + w_leds_sent * SLOT_W'(BITS_PER_LED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_duty    <= LOW_DUTY_RST;
            r_high_duty   <= HIGH_DUTY_RST;
            r_period_last <= PERIOD_LAST_RST;
            r_idle_slots  <= IDLE_SLOTS_RST;
            r_leds_in_use <= LEDS_IN_USE_RST;
            r_total       <= SLOT_W'(TOTAL_RST);
        end else begin
            r_low_duty    <= n_low_duty;
            r_high_duty   <= n_high_duty;
            r_period_last <= n_period_last;
            r_idle_slots  <= n_idle_slots;
            r_leds_in_use <= n_leds_in_use;
            r_total       <= n_total;
        end
    end

    // Handshake: the output register frees stage one, stage one frees the input.
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_s1_fire   = r_s1_valid && w_out_ready;
    assign o_in_stall  = w_clearing || (r_s1_valid && !w_out_ready);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Data bit of the current period, most significant colour bit first.
    assign w_colour_sh = w_colour << w_pos;
    assign w_bit       = w_colour_sh[COLOUR_W-1];
    assign w_duty      = w_bit ? r_high_duty : r_low_duty;
    assign w_slot_inc  = r_slot + 1'b1;

    // Stage one: execute the word against the frame state and the colour store.
    always_comb begin
        n_sending  = r_sending;
        n_slot     = r_slot;
        n_tick     = r_tick;
        w_wr_en    = 1'b0;
        w_wr_addr  = ADDR_W'(r_s1_word.led_index);
        w_wr_data  = {r_s1_word.green, r_s1_word.red, r_s1_word.blue};
        w_result   = '0;
        if (w_s1_fire) begin
            case (r_s1_word.opcode)
                OP_SET: begin
                    w_wr_en = 32'(r_s1_word.led_index) < 32'(MAX_LEDS);
                end
                OP_CLEAR: begin
                    w_wr_en   = 32'(r_s1_word.led_index) < 32'(MAX_LEDS);
                    w_wr_data = '0;
                end
                OP_START: begin
                    if (!r_sending) begin
                        n_sending = 1'b1;
                        n_slot    = '0;
                        n_tick    = '0;
                    end
                end
                OP_TICK: begin
                    if (r_sending) begin
                        if (r_slot >= r_total) begin
                            // Frame already complete, as after a shrinking write.
                            n_sending           = 1'b0;
                            w_result.frame_done = 1'b1;
                        end else begin
                            if (r_slot >= SLOT_W'(r_idle_slots)) begin
                                w_result.line_out = r_tick < w_duty;
                            end
                            if (r_tick >= r_period_last) begin
                                n_tick = '0;
                                n_slot = w_slot_inc;
                                if (w_slot_inc >= r_total) begin
                                    n_sending           = 1'b0;
                                    w_result.frame_done = 1'b1;
                                end
                            end else begin
                                n_tick = r_tick + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        w_result.busy_res = n_sending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_slot      <= '0;
            r_tick      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sending <= n_sending;
            r_slot    <= n_slot;
            r_tick    <= n_tick;
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_word <= i_in_word;
        end
        if (w_s1_fire) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The read for the next cycle follows the frame state as it will then stand.
    rlcd_slot_div #(
        .MAX_LEDS     (MAX_LEDS),
        .BITS_PER_LED (BITS_PER_LED),
        .SLOT_W       (SLOT_W),
        .ADDR_W       (ADDR_W),
        .POS_W        (POS_W)
    ) u_slot_div (
        .i_clk       (i_clk),
        .i_slot_next (n_slot),
        .i_idle_next (n_idle_slots),
        .o_rd_addr   (w_rd_addr),
        .o_pos       (w_pos)
    );

    rlcd_colour_mem #(
        .DEPTH  (MAX_LEDS),
        .ADDR_W (ADDR_W)
    ) u_colour_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_colour),
        .o_clearing (w_clearing)
    );

    // No word enters while the store is being cleared.
    `RLCD_ASSERT_IMP(a_no_accept_clearing, w_clearing, o_in_stall, "word taken while clearing")
    // A finished frame reports itself as no longer busy.
    `RLCD_ASSERT_IMP(a_done_not_busy, o_out_valid && o_out_word.frame_done,
                     !o_out_word.busy_res, "frame_done with busy set")
    // The line only goes high within a frame.
    `RLCD_ASSERT_IMP(a_line_in_frame, o_out_valid && o_out_word.line_out,
                     o_out_word.busy_res || o_out_word.frame_done, "line high outside a frame")
    // A start while idle opens a frame at its first period.
    `RLCD_ASSERT_NXT(a_start_opens, w_s1_fire && (r_s1_word.opcode == OP_START) && !r_sending,
                     r_sending && (r_slot == '0) && (r_tick == '0), "start did not open a frame")

endmodule

@@ tb/tb_rgb_led_chain_pwm_driver.sv @@
// Self-checking testbench for the single-wire RGB LED chain driver.
`timescale 1ns / 1ps

module tb_rgb_led_chain_pwm_driver;
    import rlcd_pkg::*;

    localparam int CHAIN_LEDS    = MAX_LEDS_DEF;
    localparam int LED_BITS      = BITS_PER_LED_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predicted state of the driver: colour store, frame position and registers.
    t_colour          colour_mem [CHAIN_LEDS];
    logic [7:0]       low_duty_r    = LOW_DUTY_RST;
    logic [7:0]       high_duty_r   = HIGH_DUTY_RST;
    logic [7:0]       period_last_r = PERIOD_LAST_RST;
    logic [9:0]       idle_slots_r  = IDLE_SLOTS_RST;
    logic [4:0]       leds_in_use_r = LEDS_IN_USE_RST;
    int unsigned      slot_idx      = 0;
    int unsigned      tick_cnt      = 0;
    bit               frame_active  = 1'b0;

    t_out_word        line_expected [$];
    int unsigned      useful_words   = 0;
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               src_gap_pct    = 18;
    int               sink_stall_pct = 68;

    rgb_led_chain_pwm_driver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter that ends a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Advances the predicted driver by one word and returns the line state it causes.
    // The flag tells whether the word did anything at all.
    function automatic t_out_word line_step(input t_in_word w, output bit useful);
        t_out_word   res;
        int unsigned total;
        int unsigned live;
        int unsigned d;
        int unsigned led;
        int unsigned pos;
        int unsigned duty;
        bit          one;
        res    = '0;
        useful = 1'b1;
        case (w.opcode)
            OP_SET: begin
                if (w.led_index < CHAIN_LEDS)
                    colour_mem[w.led_index] = {w.green, w.red, w.blue};
                else
                    useful = 1'b0;
            end
            OP_CLEAR: begin
                if (w.led_index < CHAIN_LEDS)
                    colour_mem[w.led_index] = '0;
                else
                    useful = 1'b0;
            end
            OP_START: begin
                if (!frame_active) begin
                    frame_active = 1'b1;
                    slot_idx     = 0;
                    tick_cnt     = 0;
                end else begin
                    useful = 1'b0;
                end
            end
            default: begin
                if (!frame_active) begin
                    useful = 1'b0;
                end else begin
                    live  = (leds_in_use_r > CHAIN_LEDS) ? CHAIN_LEDS : leds_in_use_r;
                    total = idle_slots_r + live * LED_BITS;
                    if (slot_idx >= total) begin
                        // The frame has shrunk under the counter: it ends with the line low.
                        frame_active   = 1'b0;
                        res.frame_done = 1'b1;
                    end else begin
                        if (slot_idx >= idle_slots_r) begin
                            d    = slot_idx - idle_slots_r;
                            led  = d / LED_BITS;
                            pos  = d % LED_BITS;
                            one  = (led < CHAIN_LEDS && pos < 24) ?
                                   colour_mem[5'(led)][5'(23 - pos)] : 1'b0;
                            duty = one ? high_duty_r : low_duty_r;
                            res.line_out = (tick_cnt < duty);
                        end
                        if (tick_cnt >= period_last_r) begin
                            tick_cnt = 0;
                            slot_idx++;
                            if (slot_idx >= total) begin
                                frame_active   = 1'b0;
                                res.frame_done = 1'b1;
                            end
                        end else begin
                            tick_cnt++;
                        end
                    end
                end
            end
        endcase
        res.busy_res = frame_active;
        return res;
    endfunction

    function automatic t_in_word make_word(input t_opcode op, input logic [4:0] idx,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        t_in_word w;
        w.opcode    = op;
        w.led_index = idx;
        w.red       = r;
        w.green     = g;
        w.blue      = b;
        return w;
    endfunction

    // A tick carries random junk in its unused fields.
    function automatic t_in_word tick_word();
        return make_word(OP_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // Set or clear, mostly of an LED that the frame sends, now and then out of range.
    function automatic t_in_word colour_write_word(input int unsigned live);
        logic [4:0] idx;
        t_opcode    op;
        idx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, live - 1));
        op  = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_SET;
        return make_word(op, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
    endfunction

    // Offers one word, with a random gap first, and records its expected result
    // at the edge that takes it. Returns just after that edge.
    task automatic send_word(input t_in_word w);
        bit useful;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        line_expected.push_back(line_step(w, useful));
        if (useful)
            useful_words++;
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (line_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Writes all five registers on back-to-back cycles once nothing is in flight.
    task automatic set_config(input logic [9:0] ld, input logic [9:0] hd,
                              input logic [9:0] pl, input logic [9:0] is,
                              input logic [9:0] lu);
        logic [CFG_DATA_W-1:0] vals [5];
        t_cfg_idx              regs [5];
        vals = '{ld, hd, pl, is, lu};
        regs = '{CFG_LOW_DUTY, CFG_HIGH_DUTY, CFG_PERIOD_LAST, CFG_IDLE_SLOTS,
                 CFG_LEDS_IN_USE};
        drain_results();
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            case (regs[k])
                CFG_LOW_DUTY:    low_duty_r    = vals[k][7:0];
                CFG_HIGH_DUTY:   high_duty_r   = vals[k][7:0];
                CFG_PERIOD_LAST: period_last_r = vals[k][7:0];
                CFG_IDLE_SLOTS:  idle_slots_r  = vals[k][9:0];
                default:         leds_in_use_r = vals[k][4:0];
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic tick_until_done(input int cap);
        int n;
        n = 0;
        while (frame_active && n < cap) begin
            send_word(tick_word());
            n++;
        end
    endtask

    // Ticks while idle, out-of-range writes, and a frame at the reset settings
    // that is cut short by shrinking it to nothing.
    task automatic test_idle_and_ignored();
        send_word(make_word(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_SET, 5'd24, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(OP_SET, 5'd31, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(OP_CLEAR, 5'd31, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_SET, 5'd0, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(OP_SET, 5'd23, 8'h55, 8'hAA, 8'h0F));
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(5);
        send_word(make_word(OP_START, 5'd31, 8'hFF, 8'hFF, 8'hFF));
        tick_until_done(2);
        set_config(10'd13, 10'd26, 10'd39, 10'd0, 10'd0);
        tick_until_done(4);
        send_word(tick_word());
    endtask

    // A short frame in which the store changes under the line and a start is refused.
    task automatic test_short_frame();
        set_config(10'd1, 10'd3, 10'd3, 10'd2, 10'd2);
        send_word(make_word(OP_SET, 5'd1, 8'h0F, 8'hA5, 8'hF0));
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(40);
        send_word(make_word(OP_SET, 5'd1, 8'hF0, 8'h5A, 8'h0F));
        send_word(make_word(OP_CLEAR, 5'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(2000);
    endtask

    // Duty of zero and duty past the end of the period, for both bit values.
    task automatic test_duty_extremes();
        send_word(make_word(OP_SET, 5'd0, 8'h00, 8'hFF, 8'h3C));
        set_config(10'd0, 10'd255, 10'd1, 10'd0, 10'd1);
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(2000);
        set_config(10'd255, 10'd0, 10'd1, 10'd0, 10'd1);
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(2000);
    endtask

    // Frames with no LEDs: idle periods only, then nothing at all.
    task automatic test_empty_frame();
        set_config(10'd13, 10'd26, 10'd1, 10'd3, 10'd0);
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(2000);
        set_config(10'd13, 10'd26, 10'd1, 10'd0, 10'd0);
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(2000);
    endtask

    // Largest settings, a period cut short mid-way, a frame shrunk under the counter,
    // and an LED count beyond the chain that is clamped to its length. The last frame
    // uses one tick per period, so the line shows each data bit directly.
    task automatic test_wide_settings();
        set_config(10'd13, 10'd26, 10'd255, 10'd1023, 10'd24);
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(300);
        set_config(10'd13, 10'd26, 10'd1, 10'd1023, 10'd24);
        tick_until_done(3);
        set_config(10'd13, 10'd26, 10'd1, 10'd1, 10'd0);
        tick_until_done(2000);
        set_config(10'd0, 10'd1, 10'd0, 10'd0, 10'd31);
        for (int i = 0; i < CHAIN_LEDS; i++)
            send_word(make_word(OP_SET, 5'(i), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        send_word(make_word(OP_START, 5'd0, 8'h00, 8'h00, 8'h00));
        tick_until_done(2000);
    endtask

    // One frame with random settings and content. A few have wide settings and are
    // left unfinished, some are broken off early, and stray words fall among the ticks.
    task automatic random_frame();
        logic [9:0]  ld;
        logic [9:0]  hd;
        logic [9:0]  pl;
        logic [9:0]  is;
        logic [9:0]  lu;
        int unsigned live;
        int          cap;
        ld = 10'($urandom);
        hd = 10'($urandom);
        pl = 10'($urandom);
        is = 10'($urandom);
        lu = 10'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            pl[7:0] = 8'($urandom_range(1, 255));
            lu[4:0] = 5'($urandom_range(0, 31));
            cap     = $urandom_range(20, 200);
        end else begin
            pl[7:0] = 8'($urandom_range(1, 4));
            ld[7:0] = 8'($urandom_range(0, pl[7:0] + 1));
            hd[7:0] = 8'($urandom_range(0, pl[7:0] + 1));
            is      = 10'($urandom_range(0, 3));
            lu      = 10'($urandom_range(1, 3));
            cap     = 2000;
        end
        if ($urandom_range(0, 7) == 0)
            cap = $urandom_range(1, 60);
        set_config(ld, hd, pl, is, lu);
        live = (leds_in_use_r > CHAIN_LEDS) ? CHAIN_LEDS : leds_in_use_r;
        if (live == 0)
            live = 1;
        repeat ($urandom_range(0, 4))
            send_word(colour_write_word(live));
        send_word(make_word(OP_START, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        while (frame_active && cap > 0) begin
            if ($urandom_range(0, 11) != 0)
                send_word(tick_word());
            else if ($urandom_range(0, 1) == 0)
                send_word(colour_write_word(live));
            else
                send_word(make_word(t_opcode'($urandom_range(0, 3)),
                                    5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
            cap--;
        end
    endtask

    task automatic test_random_frames(input int unsigned count);
        int unsigned first;
        first = useful_words;
        while (useful_words - first < count)
            random_frame();
    endtask

    // Compares each result taken from the driver with the oldest prediction.
    always @(posedge i_clk) begin : check_line
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (line_expected.size() == 0) begin
                mismatch_count++;
                $display("%0t: word %b arrived with none expected, expected nothing",
                         $time, o_out_word);
            end else begin
                want = line_expected.pop_front();
                if (o_out_word.line_out !== want.line_out) begin
                    mismatch_count++;
                    $display("%0t: line_out expected %b, actual %b",
                             $time, want.line_out, o_out_word.line_out);
                end
                if (o_out_word.busy_res !== want.busy_res) begin
                    mismatch_count++;
                    $display("%0t: busy_res expected %b, actual %b",
                             $time, want.busy_res, o_out_word.busy_res);
                end
                if (o_out_word.frame_done !== want.frame_done) begin
                    mismatch_count++;
                    $display("%0t: frame_done expected %b, actual %b",
                             $time, want.frame_done, o_out_word.frame_done);
                end
            end
        end
    end

    // Reset, directed tests, three random phases with different idling, then the verdict.
    initial begin
        foreach (colour_mem[i])
            colour_mem[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_ignored();
        test_short_frame();
        test_duty_extremes();
        test_empty_frame();
        test_wide_settings();

        test_random_frames(190);
        src_gap_pct    = 68;
        sink_stall_pct = 18;
        test_random_frames(190);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_frames(190);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rlcd_pkg.sv
hdl/rlcd_colour_mem.sv
hdl/rlcd_slot_div.sv
hdl/rgb_led_chain_pwm_driver.sv
tb/tb_rgb_led_chain_pwm_driver.sv
